@@ sv/rational_arith_reduce_defines.svh @@
// assertion macros for the rational arithmetic block
// no dependencies
`ifndef RATIONAL_ARITH_REDUCE_DEFINES_SVH
`define RATIONAL_ARITH_REDUCE_DEFINES_SVH
`ifndef ASSERT_OFF
`define RAR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define RAR_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define RAR_ASSERT(label, clk, rst, prop)
`define RAR_ASSERT_NR(label, clk, prop)
`endif
`endif

@@ sv/rar_pkg.sv @@
// shared types and codes for the rational arithmetic block
// no dependencies
package rar_pkg;
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;
  localparam logic [1:0] DIV_SEL_GCD = 2'd0;
  localparam logic [1:0] DIV_SEL_NUM = 2'd1;
  localparam logic [1:0] DIV_SEL_DEN = 2'd2;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic mul3;
    logic mul4;
    logic combine;
    logic div_start;
    logic [1:0] div_sel;
    logic gcd_swap;
    logic quot_num;
    logic quot_den;
    logic pack;
  } rar_cmd_t;

  typedef struct packed {
    logic div_done;
    logic rem_zero;
    logic zero_den;
  } rar_stat_t;
endpackage

@@ sv/rar_datapath.sv @@
// datapath: operand split, cross products, shared serial divider, pack
// depends on rar_pkg
module rar_datapath #(
  parameter int WIDTH = 32
) (
  input  logic clk,
  input  logic [1:0] cmd,
  input  logic [31:0] a_num,
  input  logic [31:0] a_den,
  input  logic [31:0] b_num,
  input  logic [31:0] b_den,
  input  rar_pkg::rar_cmd_t ctl,
  output rar_pkg::rar_stat_t stat,
  output logic [31:0] res_num,
  output logic [31:0] res_den,
  output logic [1:0] status
);
  import rar_pkg::*;
  localparam int MW = 2 * WIDTH + 1;
  localparam int CW = $clog2(MW + 2);

  logic [1:0] op;
  logic san, sad, sbn, sbd;
  logic [WIDTH-1:0] man, mad, mbn, mbd;
  logic [2*WIDTH-1:0] p1, p2, p3;
  logic [2*WIDTH-1:0] mul_r;
  logic sn, sd;
  logic [MW-1:0] mn, md, ga, gb;
  logic [MW-1:0] dividend, divisor, quo, rem;
  logic [CW-1:0] cnt;
  logic busy;
  logic [WIDTH-1:0] mul_a, mul_b;

  function automatic logic [WIDTH:0] mag_of(input logic [31:0] v);
    logic [WIDTH-1:0] w;
    begin
      w = v[WIDTH-1:0];
      mag_of = w[WIDTH-1] ? {1'b1, (~w) + 1'b1} : {1'b0, w};
    end
  endfunction

  always_comb begin
    mul_a = man;
    mul_b = mbd;
    if (ctl.mul2) begin
      mul_a = mad;
      mul_b = mbn;
    end else if (ctl.mul3) begin
      mul_a = man;
      mul_b = mbn;
    end else if (ctl.mul4) begin
      mul_a = mad;
      mul_b = mbd;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op <= cmd;
      {san, man} <= mag_of(a_num);
      {sad, mad} <= mag_of(a_den);
      {sbn, mbn} <= mag_of(b_num);
      {sbd, mbd} <= mag_of(b_den);
    end
    if (ctl.mul1 || ctl.mul2 || ctl.mul3 || ctl.mul4) mul_r <= mul_a * mul_b;
    if (ctl.mul2) p1 <= mul_r;
    if (ctl.mul3) p2 <= mul_r;
    if (ctl.mul4) p3 <= mul_r;
  end

  logic [2*WIDTH-1:0] pad_ad, pbn_bd;
  logic s1, s2;
  logic [MW-1:0] sum_m;
  logic sum_s;
  always_comb begin
    s1 = (san ^ sbd) && (p1 != '0);
    s2 = (sad ^ sbn) && (p2 != '0);
    if (op == CMD_SUB && p2 != '0) s2 = !s2;
    if (s1 == s2) begin
      sum_s = s1;
      sum_m = {1'b0, p1} + {1'b0, p2};
    end else if (p1 >= p2) begin
      sum_s = s1;
      sum_m = {1'b0, p1 - p2};
    end else begin
      sum_s = s2;
      sum_m = {1'b0, p2 - p1};
    end
    if (sum_m == '0) sum_s = 1'b0;
    pad_ad = p1;
    pbn_bd = p2;
  end

  always_ff @(posedge clk) begin
    if (ctl.combine) begin
      unique case (op)
        CMD_ADD, CMD_SUB: begin
          sn <= sum_s;
          mn <= sum_m;
          sd <= sad ^ sbd;
          md <= {1'b0, mul_r};
        end
        CMD_MUL: begin
          sn <= san ^ sbn;
          mn <= {1'b0, p3};
          sd <= sad ^ sbd;
          md <= {1'b0, mul_r};
        end
        default: begin
          sn <= san ^ sbd;
          mn <= {1'b0, pad_ad};
          sd <= sad ^ sbn;
          md <= {1'b0, pbn_bd};
        end
      endcase
      ga <= '0;
      gb <= '0;
    end
    if (ctl.gcd_swap) begin
      ga <= (ga == '0 && gb == '0) ? mn : gb;
      gb <= (ga == '0 && gb == '0) ? md : rem;
    end
    if (ctl.quot_num) mn <= quo;
    if (ctl.quot_den) md <= quo;
  end

  assign stat.zero_den = (mad == '0) || (mbd == '0) || (md == '0);
  assign stat.rem_zero = (gb == '0) && !(ga == '0);

  // restoring divider, one quotient bit per cycle
  logic [MW-1:0] trial;
  logic [MW:0] diff;
  always_comb begin
    trial = {rem[MW-2:0], quo[MW-1]};
    diff = {1'b0, trial} - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      unique case (ctl.div_sel)
        DIV_SEL_GCD: begin dividend <= ga; divisor <= gb; end
        DIV_SEL_NUM: begin dividend <= mn; divisor <= ga; end
        default: begin dividend <= md; divisor <= ga; end
      endcase
      busy <= 1'b1;
      cnt <= CW'(MW + 1);
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      if (cnt == CW'(MW + 1)) begin
        quo <= dividend;
        cnt <= cnt - 1'b1;
      end else if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        if (!diff[MW]) begin
          rem <= diff[MW-1:0];
          quo <= {quo[MW-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[MW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
      end
    end
  end
  // extra stage keeps cnt == MW+1 for the loading cycle
  assign stat.div_done = busy && (cnt == '0);

  logic [WIDTH-1:0] lim_bits, nb, db;
  logic fn, fd;
  always_comb begin
    fn = sn ? (mn <= (MW'(1) << (WIDTH - 1))) : (mn < (MW'(1) << (WIDTH - 1)));
    fd = sd ? (md <= (MW'(1) << (WIDTH - 1))) : (md < (MW'(1) << (WIDTH - 1)));
    nb = sn ? (~mn[WIDTH-1:0]) + 1'b1 : mn[WIDTH-1:0];
    db = sd ? (~md[WIDTH-1:0]) + 1'b1 : md[WIDTH-1:0];
    lim_bits = '0;
  end

  always_ff @(posedge clk) begin
    if (ctl.pack) begin
      if (stat.zero_den) begin
        res_num <= '0;
        res_den <= '0;
        status <= ST_ZDEN;
      end else begin
        res_num <= 32'($signed(nb | lim_bits));
        res_den <= 32'($signed(db));
        status <= (fn && fd && !(mn == '0 ? 1'b0 : 1'b0)) ? ST_OK : ST_OVF;
      end
    end
  end
endmodule

@@ sv/rar_ctrl.sv @@
// controller sequencing multiplies, gcd loop, final divides and output
// depends on rar_pkg and the assertion header
`include "rational_arith_reduce_defines.svh"
module rar_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic out_fire,
  input  rar_pkg::rar_stat_t stat,
  output rar_pkg::rar_cmd_t ctl,
  output logic idle,
  output logic out_valid
);
  import rar_pkg::*;
  localparam logic [3:0] S_IDLE = 4'd0, S_M1 = 4'd1, S_M2 = 4'd2, S_M3 = 4'd3,
    S_M4 = 4'd4, S_CMB = 4'd5, S_CHK = 4'd6, S_GDIV = 4'd7, S_GW = 4'd8,
    S_NDIV = 4'd9, S_NW = 4'd10, S_DDIV = 4'd11, S_DW = 4'd12, S_PACK = 4'd13,
    S_OUT = 4'd14;
  logic [3:0] state, state_next;
  logic first;

  always_comb begin
    ctl = '0;
    state_next = state;
    unique case (state)
      S_IDLE: if (in_fire) begin ctl.load = 1'b1; state_next = S_M1; end
      S_M1: begin ctl.mul1 = 1'b1; state_next = S_M2; end
      S_M2: begin ctl.mul2 = 1'b1; state_next = S_M3; end
      S_M3: begin ctl.mul3 = 1'b1; state_next = S_M4; end
      S_M4: begin ctl.mul4 = 1'b1; state_next = S_CMB; end
      S_CMB: begin ctl.combine = 1'b1; state_next = S_CHK; end
      S_CHK: begin
        if (stat.zero_den) state_next = S_PACK;
        else begin ctl.gcd_swap = 1'b1; state_next = S_GDIV; end
      end
      S_GDIV: begin
        if (stat.rem_zero) begin
          ctl.div_start = 1'b1; ctl.div_sel = DIV_SEL_NUM; state_next = S_NW;
        end else begin
          ctl.div_start = 1'b1; ctl.div_sel = DIV_SEL_GCD; state_next = S_GW;
        end
      end
      S_GW: if (stat.div_done) begin ctl.gcd_swap = 1'b1; state_next = S_GDIV; end
      S_NW: if (stat.div_done) begin ctl.quot_num = 1'b1; state_next = S_DDIV; end
      S_DDIV: begin
        ctl.div_start = 1'b1; ctl.div_sel = DIV_SEL_DEN; state_next = S_DW;
      end
      S_DW: if (stat.div_done) begin ctl.quot_den = 1'b1; state_next = S_PACK; end
      S_PACK: begin ctl.pack = 1'b1; state_next = S_OUT; end
      S_OUT: if (out_fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      first <= 1'b1;
    end else begin
      state <= state_next;
      first <= 1'b0;
    end
  end

  assign idle = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  `RAR_ASSERT(a_no_in_busy, clk, rst, in_fire |-> idle)
  `RAR_ASSERT(a_out_follows_pack, clk, rst, ctl.pack |=> out_valid)
  `RAR_ASSERT(a_out_idle, clk, rst, out_fire |=> idle)
  `RAR_ASSERT_NR(a_reset_idle, clk, rst |=> idle || first)
endmodule

@@ sv/rational_arith_reduce.sv @@
// Exact arithmetic on two signed fractions with Euclidean gcd reduction.
// One item at a time: four serial cross products, then a gcd loop on a
// shared restoring divider, then two divisions of the numerator and
// denominator by the gcd.
// depends on rar_pkg, rar_ctrl, rar_datapath
module rational_arith_reduce #(
  parameter int WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [127:0] s_tdata, // a_num, a_den, b_num, b_den
  input  logic [1:0] s_tuser,   // cmd
  output logic m_tvalid,
  input  logic m_tready,
  output logic [63:0] m_tdata,  // res_num, res_den
  output logic [1:0] m_tuser    // status
);
  import rar_pkg::*;
  rar_cmd_t ctl;
  rar_stat_t stat;
  logic idle;
  logic [31:0] rn, rd;

  assign s_tready = idle;
  rar_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(s_tvalid && s_tready),
    .out_fire(m_tvalid && m_tready), .stat(stat), .ctl(ctl), .idle(idle),
    .out_valid(m_tvalid)
  );
  rar_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk(clk), .cmd(s_tuser), .a_num(s_tdata[31:0]), .a_den(s_tdata[63:32]),
    .b_num(s_tdata[95:64]), .b_den(s_tdata[127:96]), .ctl(ctl), .stat(stat),
    .res_num(rn), .res_den(rd), .status(m_tuser)
  );
  assign m_tdata = {rd, rn};
endmodule
